FILE: rtl/aes_pkg.sv
// Shared definitions for the AES-128 ECB/CBC encryptor: S-box table,
// round functions, key schedule step and configuration register indexes.
// Used by the top level and by its port checker.
package aes_pkg;

  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned RND_CNT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HIGH   = 3'd0,
    CFG_KEY_LOW    = 3'd1,
    CFG_IV_HIGH    = 3'd2,
    CFG_IV_LOW     = 3'd3,
    CFG_CHAIN_MODE = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant for the key step that produces round key n (1..10).
  function automatic logic [7:0] rcon(logic [RND_CNT_W-1:0] n);
    logic [7:0] rc;
    case (n)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block sits at bits [127-8k -: 8] (first byte most significant).
  function automatic logic [BLOCK_W-1:0] sub_bytes(logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    for (int k = 0; k < 16; k++) begin
      r[BLOCK_W-1-8*k -: 8] = SBOX[s[BLOCK_W-1-8*k -: 8]];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] shift_rows(logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) % 4) + r;
        t[BLOCK_W-1-8*(4*c+r) -: 8] = s[BLOCK_W-1-8*src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(logic [BLOCK_W-1:0] t);
    logic [BLOCK_W-1:0] s;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = t[BLOCK_W-1-32*c      -: 8];
      a1  = t[BLOCK_W-1-32*c - 8  -: 8];
      a2  = t[BLOCK_W-1-32*c - 16 -: 8];
      a3  = t[BLOCK_W-1-32*c - 24 -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      s[BLOCK_W-1-32*c      -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      s[BLOCK_W-1-32*c - 8  -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      s[BLOCK_W-1-32*c - 16 -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      s[BLOCK_W-1-32*c - 24 -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return s;
  endfunction

  // Produce the next round key (four words, first word high) from the previous one.
  function automatic logic [BLOCK_W-1:0] key_step(logic [BLOCK_W-1:0] k, logic [7:0] rc);
    logic [31:0] rot, sw, w0, w1, w2, w3;
    rot = {k[23:0], k[31:24]};
    sw  = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
    w0  = k[127:96] ^ sw ^ {rc, 24'h000000};
    w1  = k[95:64] ^ w0;
    w2  = k[63:32] ^ w1;
    w3  = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

FILE: rtl/aes128_ecb_cbc_encrypt.sv
// Top level of the AES-128 ECB/CBC block encryptor.
// Depends on aes_pkg for the S-box, round functions and register indexes.
//
// One 128-bit plaintext word enters per cycle and one ciphertext word leaves
// per cycle while neither in_stall_o nor out_stall_i holds the flow: the word
// is held in an input register, all ten AES rounds and the CBC chaining XOR
// run in one combinational pass, and the result lands in the output register
// together with the new chaining value. Because the chaining value is written
// at the same edge as the result, CBC words still follow back to back. The
// input register doubles as a skid stage, so one more word is taken while a
// result waits on out_stall_i. After reset, and after each write of key_high
// or key_low, the round keys are expanded one round per cycle into a register
// file, and in_stall_o stays high until they are all written. In CBC mode the
// first word of a message is XORed with the IV, later words with the previous
// ciphertext; a word marked last_block makes the next CBC word use the IV
// again. Write configuration only while no word is in flight.
module aes128_ecb_cbc_encrypt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [aes_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [aes_pkg::HALF_W-1:0]          cfg_wdata_i,
  // plaintext channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [aes_pkg::HALF_W-1:0]          plain_high_i,
  input  logic [aes_pkg::HALF_W-1:0]          plain_low_i,
  input  logic                                last_block_i,
  // ciphertext channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [aes_pkg::HALF_W-1:0]          cipher_high_o,
  output logic [aes_pkg::HALF_W-1:0]          cipher_low_o,
  output logic                                end_of_message_o
);

  localparam int unsigned BW = aes_pkg::BLOCK_W;
  localparam int unsigned HW = aes_pkg::HALF_W;
  localparam int unsigned NR = aes_pkg::NUM_ROUNDS;
  localparam int unsigned CW = aes_pkg::RND_CNT_W;

  // Configuration registers
  logic [BW-1:0] key_q;
  logic [BW-1:0] iv_q;
  logic          mode_q;
  logic          key_wr;

  // Key schedule: round keys, running key and round counter
  logic [BW-1:0] rk_q [NR+1];
  logic [BW-1:0] kw_q;
  logic [BW-1:0] kw_next;
  logic [CW-1:0] ks_cnt_q, ks_cnt_d;
  logic          ks_busy_q, ks_busy_d;

  // Input stage, output stage and chaining state
  logic          s1_valid_q, s1_valid_d;
  logic [BW-1:0] s1_data_q;
  logic          s1_last_q;
  logic          out_valid_q, out_valid_d;
  logic [BW-1:0] out_data_q;
  logic          out_last_q;
  logic [BW-1:0] chain_q;
  logic          chain_valid_q, chain_valid_d;

  logic          in_fire, out_move, s1_fire;
  logic [BW-1:0] chain_xor;
  logic [BW-1:0] rnd_st [NR+1];

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign key_wr = cfg_we_i && ((cfg_idx_i == aes_pkg::CFG_KEY_HIGH) ||
                               (cfg_idx_i == aes_pkg::CFG_KEY_LOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      iv_q   <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aes_pkg::CFG_KEY_HIGH:   key_q[BW-1:HW] <= cfg_wdata_i;
        aes_pkg::CFG_KEY_LOW:    key_q[HW-1:0]  <= cfg_wdata_i;
        aes_pkg::CFG_IV_HIGH:    iv_q[BW-1:HW]  <= cfg_wdata_i;
        aes_pkg::CFG_IV_LOW:     iv_q[HW-1:0]   <= cfg_wdata_i;
        aes_pkg::CFG_CHAIN_MODE: mode_q         <= cfg_wdata_i[0];
        default: ;  // indexes beyond the list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Key expansion: step 0 copies the key, steps 1..10 derive one round key each
  // ---------------------------------------------------------------------------
  assign kw_next = aes_pkg::key_step(kw_q, aes_pkg::rcon(ks_cnt_q));

  always_comb begin
    ks_busy_d = ks_busy_q;
    ks_cnt_d  = ks_cnt_q;
    if (key_wr) begin
      // restart from the new key, even mid-expansion
      ks_busy_d = 1'b1;
      ks_cnt_d  = '0;
    end else if (ks_busy_q) begin
      if (ks_cnt_q == CW'(NR)) begin
        ks_busy_d = 1'b0;
      end else begin
        ks_cnt_d = ks_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_busy_q <= 1'b1;  // expand the reset key before the first word
      ks_cnt_q  <= '0;
    end else begin
      ks_busy_q <= ks_busy_d;
      ks_cnt_q  <= ks_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ks_busy_q && !key_wr) begin
      if (ks_cnt_q == '0) begin
        rk_q[0] <= key_q;
        kw_q    <= key_q;
      end else begin
        rk_q[ks_cnt_q] <= kw_next;
        kw_q           <= kw_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register acts as skid stage in front of the output register
  // ---------------------------------------------------------------------------
  assign out_move   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_move;
  assign in_stall_o = ks_busy_q || (s1_valid_q && !out_move);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_move ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= {plain_high_i, plain_low_i};
      s1_last_q <= last_block_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Encryption datapath: chaining XOR, initial key add, ten rounds
  // ---------------------------------------------------------------------------
  assign chain_xor = mode_q ? (chain_valid_q ? chain_q : iv_q) : '0;
  assign rnd_st[0] = s1_data_q ^ chain_xor ^ rk_q[0];

  for (genvar r = 1; r < NR; r++) begin : g_round
    assign rnd_st[r] = aes_pkg::mix_columns(aes_pkg::shift_rows(
                         aes_pkg::sub_bytes(rnd_st[r-1]))) ^ rk_q[r];
  end

  // final round has no column mix
  assign rnd_st[NR] = aes_pkg::shift_rows(aes_pkg::sub_bytes(rnd_st[NR-1])) ^ rk_q[NR];

  // ---------------------------------------------------------------------------
  // Chaining state advances at the same edge as the result register
  // ---------------------------------------------------------------------------
  always_comb begin
    chain_valid_d = chain_valid_q;
    if (s1_fire) begin
      if (mode_q) begin
        chain_valid_d = 1'b1;
      end
      if (s1_last_q) begin
        chain_valid_d = 1'b0;  // next CBC word starts from the IV
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_valid_q <= 1'b0;
      chain_q       <= '0;
    end else begin
      chain_valid_q <= chain_valid_d;
      if (s1_fire && mode_q) begin
        chain_q <= rnd_st[NR];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= rnd_st[NR];
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cipher_high_o    = out_data_q[BW-1:HW];
  assign cipher_low_o     = out_data_q[HW-1:0];
  assign end_of_message_o = out_last_q;

endmodule

FILE: rtl/aes_chk.sv
// Port checker for the AES-128 ECB/CBC encryptor, bound to its top level.
// Depends on aes_pkg for the configuration register indexes.
module aes_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [aes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [aes_pkg::HALF_W-1:0]     cipher_high_o,
  input logic [aes_pkg::HALF_W-1:0]     cipher_low_o,
  input logic                           end_of_message_o
);

  logic key_wr;

  assign key_wr = cfg_we_i && ((cfg_idx_i == aes_pkg::CFG_KEY_HIGH) ||
                               (cfg_idx_i == aes_pkg::CFG_KEY_LOW));

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cipher_high_o) && $stable(cipher_low_o) &&
                                   $stable(end_of_message_o))
    else $error("result word changed while stalled");

  // a key write blocks input while the round keys are rebuilt
  a_key_stall_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |=> in_stall_o)
    else $error("input taken right after a key write");

  a_key_stall_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |-> ##10 in_stall_o)
    else $error("input taken before key expansion finished");

endmodule

bind aes128_ecb_cbc_encrypt aes_chk u_aes_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_we_i         (cfg_we_i),
  .cfg_idx_i        (cfg_idx_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .cipher_high_o    (cipher_high_o),
  .cipher_low_o     (cipher_low_o),
  .end_of_message_o (end_of_message_o)
);
